// File: hw/rtl/cflp_pkg.sv
// cflp_pkg: shared types and codes of the circular flash log pointer unit
// holds the transaction structs, log geometry, status/function/register codes
// and the divider request/response structs; used by cflp_div and the top level
`timescale 1ns / 1ps

package cflp_pkg;

    // log geometry
    localparam int SLOTS_PER_PAGE = 16;
    localparam int SECTOR_PAGES   = 16;
    localparam int MAX_PAGES      = 4096;
    localparam int SLOT_BITS      = $clog2(SLOTS_PER_PAGE);
    localparam int SECTOR_BITS    = $clog2(SECTOR_PAGES);

    // field types of the request and response transactions
    typedef logic [1:0]  status_t;
    typedef logic [11:0] page_t;
    typedef logic [3:0]  slot_t;
    typedef logic [7:0]  sector_t;
    typedef logic [31:0] count_t;
    typedef logic [31:0] index_t;

    // configuration port
    typedef logic [1:0]  cfg_index_t;
    typedef logic [12:0] cfg_data_t;

    localparam cfg_index_t CFG_PAGE_COUNT = 2'd0;
    localparam cfg_index_t CFG_ENABLE     = 2'd1;

    localparam cfg_data_t  PAGE_COUNT_RST = 13'd4096;

    // request function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // response status codes
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_REFUSED = 2'd1;
    localparam status_t STATUS_RANGE   = 2'd2;

    typedef struct packed {
        logic   func;
        index_t index;
    } req_t;

    typedef struct packed {
        status_t status;
        page_t   page;
        slot_t   slot;
        logic    erase_request;
        sector_t erase_target;
        count_t  record_count;
    } rsp_t;

    // shared divider
    localparam int DIV_W = 32;

    typedef logic [DIV_W-1:0] div_word_t;

    typedef struct packed {
        logic      start;
        div_word_t dividend;
        div_word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic      busy;
        logic      done;
        div_word_t remainder;
    } div_rsp_t;

endpackage

// File: hw/rtl/cflp_div.sv
// cflp_div: shared restoring divider, one quotient bit per cycle
// takes a start pulse with operands, pulses done with the remainder
// depends on cflp_pkg for the request/response structs
`timescale 1ns / 1ps

module cflp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cflp_pkg::div_req_t req,
    output cflp_pkg::div_rsp_t rsp
);

    localparam int W     = cflp_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;
    logic             small_op;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[W-1]};
        ge       = (shifted >= {1'b0, dvs_reg});
        diff     = shifted - {1'b0, dvs_reg};
        small_op = (req.dividend < req.divisor);
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (small_op)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(W - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvs_reg <= req.divisor;
            if (small_op)
            begin
                rem_reg <= req.dividend;
                quo_reg <= '0;
            end
            else
            begin
                rem_reg <= '0;
                quo_reg <= req.dividend;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    always_comb
    begin
        rsp.busy      = busy_reg;
        rsp.done      = done_reg;
        rsp.remainder = rem_reg;
    end

endmodule

// File: hw/rtl/circular_flash_log_pointer_unit.sv
// circular_flash_log_pointer_unit: write pointer, record count and lookup
// sequencer for a circular flash log; all run-time division goes
// through one cflp_div instance; depends on cflp_pkg
`timescale 1ns / 1ps

// Usage:
//   req channel (req_valid/req_stall/req_data): func selects append or lookup,
//   index gives records back from the newest for a lookup.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one response per request with
//   status, page/slot, erase request/sector and the record count after it.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): page_count at index 0,
//   enable at index 1; cfg_ready is always high, write only while idle.
// Timing: one request at a time; req_stall is high while it is worked on.
//   Each pass through the shared divider skips the iteration when the dividend
//   is below the divisor. An append within a page, a refused append or an out
//   of range lookup goes straight to the output state after accept; a page
//   change adds one divider pass and a sector entry one more when the area
//   holds at least one sector. A lookup runs a prepare and a start state, then
//   two divider passes. The next request is taken in the cycle after the response is loaded.
// The response sits in an output register; a new request is taken while it
// waits. If rsp_stall holds it, the next response waits in the last state.
// Reset: pointer, slot and count clear, page_count is 4096, enable is 1.

module circular_flash_log_pointer_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  cflp_pkg::req_t       req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output cflp_pkg::rsp_t       rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cflp_pkg::cfg_index_t cfg_index,
    input  cflp_pkg::cfg_data_t  cfg_data
);

    localparam int SLOT_W  = cflp_pkg::SLOT_BITS;
    localparam int SINC_W  = SLOT_W + 1;
    localparam int PTR_W   = $clog2(cflp_pkg::MAX_PAGES);
    localparam int PINC_W  = PTR_W + 1;
    localparam int PAGES_W = $clog2(cflp_pkg::MAX_PAGES + 1);
    localparam int SEC_W   = PTR_W - cflp_pkg::SECTOR_BITS;
    localparam int SECI_W  = SEC_W + 1;
    localparam int SCNT_W  = PAGES_W - cflp_pkg::SECTOR_BITS;
    localparam int TOT_W   = $clog2(cflp_pkg::MAX_PAGES * cflp_pkg::SLOTS_PER_PAGE + 1);
    localparam int TGT_W   = TOT_W + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_A_PTR   = 3'd1;
    localparam logic [2:0] S_A_ES    = 3'd2;
    localparam logic [2:0] S_L_PREP  = 3'd3;
    localparam logic [2:0] S_L_START = 3'd4;
    localparam logic [2:0] S_L_LIN   = 3'd5;
    localparam logic [2:0] S_L_BACK  = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0]          state_reg, state_next;
    cflp_pkg::cfg_data_t page_count_reg;
    logic                enable_reg;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    cflp_pkg::count_t    total_reg, total_next;
    cflp_pkg::index_t    idx_reg, idx_next;
    logic [PAGES_W-1:0]  pages_reg, pages_next;
    logic [TOT_W-1:0]    tot_reg, tot_next;
    logic [TOT_W-1:0]    lin_reg, lin_next;
    cflp_pkg::status_t   res_status_reg, res_status_next;
    cflp_pkg::page_t     res_page_reg, res_page_next;
    cflp_pkg::slot_t     res_slot_reg, res_slot_next;
    logic                res_er_reg, res_er_next;
    cflp_pkg::sector_t   res_es_reg, res_es_next;
    logic                rsp_valid_reg, rsp_valid_next;
    cflp_pkg::rsp_t      rsp_data_reg, rsp_data_next;

    logic                req_accept;
    logic [PAGES_W-1:0]  pages_eff;
    logic [SINC_W-1:0]   slot_inc;
    logic [PTR_W-1:0]    ptr_wrap;
    logic [SCNT_W-1:0]   sectors;
    logic [SECI_W-1:0]   sec_inc;
    logic [TGT_W-1:0]    t_sum;
    logic [TOT_W-1:0]    t_pos;

    cflp_pkg::div_req_t  div_req;
    cflp_pkg::div_rsp_t  div_rsp;

    cflp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    // effective page count: zero or oversize reads as the maximum
    always_comb
    begin
        if (page_count_reg == '0 || 32'(page_count_reg) > 32'(cflp_pkg::MAX_PAGES))
            pages_eff = PAGES_W'(cflp_pkg::MAX_PAGES);
        else
            pages_eff = PAGES_W'(page_count_reg);
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        slot_next       = slot_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        pages_next      = pages_reg;
        tot_next        = tot_reg;
        lin_next        = lin_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_slot_next   = res_slot_reg;
        res_er_next     = res_er_reg;
        res_es_next     = res_es_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_data_next   = rsp_data_reg;
        div_req         = '0;

        slot_inc = SINC_W'(slot_reg) + SINC_W'(1);
        // wrapped pointer, sector count and the sector after the current one
        ptr_wrap = PTR_W'(div_rsp.remainder);
        sectors  = pages_reg[PAGES_W-1:cflp_pkg::SECTOR_BITS];
        sec_inc  = SECI_W'(ptr_wrap[PTR_W-1:cflp_pkg::SECTOR_BITS]) + SECI_W'(1);
        // newest position minus records back, kept below twice the total
        t_sum    = TGT_W'(lin_reg) + TGT_W'(tot_reg) - TGT_W'(1)
                   - TGT_W'(TOT_W'(div_rsp.remainder));
        if (t_sum >= TGT_W'(tot_reg))
            t_pos = TOT_W'(t_sum - TGT_W'(tot_reg));
        else
            t_pos = TOT_W'(t_sum);

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    idx_next        = req_data.index;
                    pages_next      = pages_eff;
                    res_status_next = cflp_pkg::STATUS_OK;
                    res_page_next   = '0;
                    res_slot_next   = '0;
                    res_er_next     = 1'b0;
                    res_es_next     = '0;
                    if (req_data.func == cflp_pkg::FUNC_APPEND)
                    begin
                        if (!enable_reg)
                        begin
                            res_status_next = cflp_pkg::STATUS_REFUSED;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            res_page_next = cflp_pkg::page_t'(ptr_reg);
                            res_slot_next = cflp_pkg::slot_t'(slot_reg);
                            if (total_reg != '1)
                                total_next = total_reg + 1'b1;
                            if (slot_inc == SINC_W'(cflp_pkg::SLOTS_PER_PAGE))
                            begin
                                // page full: next page modulo the page count
                                slot_next        = '0;
                                div_req.start    = 1'b1;
                                div_req.dividend =
                                    cflp_pkg::div_word_t'(PINC_W'(ptr_reg) + PINC_W'(1));
                                div_req.divisor  = cflp_pkg::div_word_t'(pages_eff);
                                state_next       = S_A_PTR;
                            end
                            else
                            begin
                                slot_next  = SLOT_W'(slot_inc);
                                state_next = S_OUT;
                            end
                        end
                    end
                    else if (req_data.index >= total_reg)
                    begin
                        res_status_next = cflp_pkg::STATUS_RANGE;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_L_PREP;
                    end
                end
            end

            S_A_PTR:
            begin
                if (div_rsp.done)
                begin
                    ptr_next = ptr_wrap;
                    if (ptr_wrap[cflp_pkg::SECTOR_BITS-1:0] == '0)
                    begin
                        // entered a new sector: erase the one after it
                        res_er_next = 1'b1;
                        if (sectors == '0)
                        begin
                            res_es_next = '0;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = cflp_pkg::div_word_t'(sec_inc);
                            div_req.divisor  = cflp_pkg::div_word_t'(sectors);
                            state_next       = S_A_ES;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_A_ES:
            begin
                if (div_rsp.done)
                begin
                    res_es_next = cflp_pkg::sector_t'(div_rsp.remainder);
                    state_next  = S_OUT;
                end
            end

            S_L_PREP:
            begin
                tot_next   = TOT_W'(pages_reg) << SLOT_W;
                lin_next   = TOT_W'({ptr_reg, slot_reg});
                state_next = S_L_START;
            end

            S_L_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cflp_pkg::div_word_t'(lin_reg);
                div_req.divisor  = cflp_pkg::div_word_t'(tot_reg);
                state_next       = S_L_LIN;
            end

            S_L_LIN:
            begin
                if (div_rsp.done)
                begin
                    lin_next         = TOT_W'(div_rsp.remainder);
                    div_req.start    = 1'b1;
                    div_req.dividend = idx_reg;
                    div_req.divisor  = cflp_pkg::div_word_t'(tot_reg);
                    state_next       = S_L_BACK;
                end
            end

            S_L_BACK:
            begin
                if (div_rsp.done)
                begin
                    // target position split into page and slot
                    res_page_next = cflp_pkg::page_t'(t_pos[TOT_W-1:SLOT_W]);
                    res_slot_next = cflp_pkg::slot_t'(t_pos[SLOT_W-1:0]);
                    state_next    = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.status        = res_status_reg;
                    rsp_data_next.page          = res_page_reg;
                    rsp_data_next.slot          = res_slot_reg;
                    rsp_data_next.erase_request = res_er_reg;
                    rsp_data_next.erase_target  = res_es_reg;
                    rsp_data_next.record_count  = total_reg;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, log state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            slot_reg       <= '0;
            total_reg      <= '0;
            page_count_reg <= cflp_pkg::PAGE_COUNT_RST;
            enable_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            ptr_reg       <= ptr_next;
            slot_reg      <= slot_next;
            total_reg     <= total_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cflp_pkg::CFG_PAGE_COUNT: page_count_reg <= cfg_data;
                    cflp_pkg::CFG_ENABLE:     enable_reg     <= cfg_data[0];
                    default:                  ;
                endcase
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pages_reg      <= pages_next;
        tot_reg        <= tot_next;
        lin_reg        <= lin_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_slot_reg   <= res_slot_next;
        res_er_reg     <= res_er_next;
        res_es_reg     <= res_es_next;
        rsp_data_reg   <= rsp_data_next;
    end

`ifndef SYNTHESIS
    // a response only appears out of the output state
    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("response raised outside the output state");

    // the sequencer never restarts the divider while it iterates
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // slot index stays inside a page
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < 32'(cflp_pkg::SLOTS_PER_PAGE))
        else $error("slot index out of page");

    // refused or out of range responses carry no position and no erase
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.status != cflp_pkg::STATUS_OK |->
        rsp_data_reg.page == '0 && rsp_data_reg.slot == '0
        && !rsp_data_reg.erase_request && rsp_data_reg.erase_target == '0)
        else $error("error response with nonzero position");
`endif

endmodule

// File: tb/sv/circular_flash_log_pointer_unit_tb.sv
// circular_flash_log_pointer_unit_tb: self-checking bench for the flash log pointer unit
// directed table then randomized phases, each response checked against a local
// position predictor or a typed table entry; depends on cflp_pkg and circular_flash_log_pointer_unit
`timescale 1ns / 1ps

module circular_flash_log_pointer_unit_tb;

    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // register indexes with no register behind them
    localparam cflp_pkg::cfg_index_t CFG_SPARE_A = 2'd2;
    localparam cflp_pkg::cfg_index_t CFG_SPARE_B = 2'd3;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        cflp_pkg::cfg_index_t reg_idx;
        cflp_pkg::cfg_data_t  reg_val;
        cflp_pkg::req_t       req;
        int                   reps;
        bit                   typed;
        cflp_pkg::rsp_t       want;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    cflp_pkg::req_t       req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    cflp_pkg::rsp_t       rsp_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cflp_pkg::cfg_index_t cfg_index = '0;
    cflp_pkg::cfg_data_t  cfg_data  = '0;

    // predictor copy of registers and pointer state
    cflp_pkg::cfg_data_t model_page_count = cflp_pkg::PAGE_COUNT_RST;
    logic                model_enable     = 1'b1;
    int unsigned         wr_page          = 0;
    int unsigned         wr_slot          = 0;
    int unsigned         rec_total        = 0;

    cflp_pkg::rsp_t      expected_positions[$];
    stim_row_t           plan[$];
    int unsigned         mismatch_count = 0;
    bit                  idle_on        = 1'b1;
    int                  idle_cycles    = 0;
    int                  stall_left     = 0;

    circular_flash_log_pointer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // expected response for one request, advancing the pointer state
    function automatic cflp_pkg::rsp_t predict_log_position(cflp_pkg::req_t r);
        int unsigned       pages;
        int unsigned       sectors;
        longint unsigned   ring;
        longint unsigned   lin;
        longint unsigned   back;
        longint unsigned   tgt;
        cflp_pkg::rsp_t    res;
        pages = (model_page_count == 0 || model_page_count > cflp_pkg::MAX_PAGES)
                ? cflp_pkg::MAX_PAGES : model_page_count;
        res = '0;
        if (r.func == cflp_pkg::FUNC_APPEND)
        begin
            if (!model_enable)
                res.status = cflp_pkg::STATUS_REFUSED;
            else
            begin
                res.status = cflp_pkg::STATUS_OK;
                res.page   = cflp_pkg::page_t'(wr_page);
                res.slot   = cflp_pkg::slot_t'(wr_slot);
                wr_slot    = (wr_slot + 1) % cflp_pkg::SLOTS_PER_PAGE;
                if (rec_total != 32'hFFFF_FFFF)
                    rec_total++;
                // page change, and erase ahead on sector entry
                if (wr_slot == 0)
                begin
                    wr_page = (wr_page + 1) % pages;
                    if (wr_page % cflp_pkg::SECTOR_PAGES == 0)
                    begin
                        sectors = pages / cflp_pkg::SECTOR_PAGES;
                        res.erase_request = 1'b1;
                        if (sectors != 0)
                            res.erase_target = cflp_pkg::sector_t'(
                                (wr_page / cflp_pkg::SECTOR_PAGES + 1) % sectors);
                    end
                end
            end
        end
        else if (r.index >= rec_total)
            res.status = cflp_pkg::STATUS_RANGE;
        else
        begin
            // step back from the write position around the slot ring
            ring = pages;
            ring = ring * cflp_pkg::SLOTS_PER_PAGE;
            lin  = wr_page;
            lin  = (lin * cflp_pkg::SLOTS_PER_PAGE + wr_slot) % ring;
            back = r.index;
            back = back % ring;
            tgt  = (lin + 2 * ring - 1 - back) % ring;
            res.status = cflp_pkg::STATUS_OK;
            res.page   = cflp_pkg::page_t'(tgt / cflp_pkg::SLOTS_PER_PAGE);
            res.slot   = cflp_pkg::slot_t'(tgt % cflp_pkg::SLOTS_PER_PAGE);
        end
        res.record_count = rec_total;
        return res;
    endfunction

    // stimulus table builders
    function automatic void add_cfg(cflp_pkg::cfg_index_t idx, cflp_pkg::cfg_data_t val);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.req     = '0;
        row.reps    = 0;
        row.typed   = 1'b0;
        row.want    = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_req(logic func, cflp_pkg::index_t idx, int reps);
        stim_row_t row;
        row.kind      = ROW_REQ;
        row.reg_idx   = '0;
        row.reg_val   = '0;
        row.req.func  = func;
        row.req.index = idx;
        row.reps      = reps;
        row.typed     = 1'b0;
        row.want      = '0;
        plan.push_back(row);
    endfunction

    // rows whose response is all zero but status and count
    function automatic void add_chk(logic func, cflp_pkg::index_t idx,
                                    cflp_pkg::status_t st, cflp_pkg::count_t cnt);
        stim_row_t row;
        row.kind              = ROW_REQ;
        row.reg_idx           = '0;
        row.reg_val           = '0;
        row.req.func          = func;
        row.req.index         = idx;
        row.reps              = 1;
        row.typed             = 1'b1;
        row.want              = '0;
        row.want.status       = st;
        row.want.record_count = cnt;
        plan.push_back(row);
    endfunction

    function automatic cflp_pkg::req_t random_request();
        cflp_pkg::req_t r;
        r.index = $urandom;
        if ($urandom_range(0, 99) < 55)
            r.func = cflp_pkg::FUNC_APPEND;
        else
        begin
            r.func = cflp_pkg::FUNC_LOOKUP;
            case ($urandom_range(0, 5))
                0: ;
                1: r.index = '0;
                2: r.index = rec_total;
                3: r.index = rec_total - 1;
                default: r.index = $urandom_range(0, rec_total - 1);
            endcase
        end
        return r;
    endfunction

    // hold off requests until every response is back, then let the unit settle
    task automatic drain_responses(int settle);
        req_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(cflp_pkg::cfg_index_t idx, cflp_pkg::cfg_data_t val);
        drain_responses(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == cflp_pkg::CFG_PAGE_COUNT)
            model_page_count = val;
        else if (idx == cflp_pkg::CFG_ENABLE)
            model_enable = val[0];
        cfg_valid <= 1'b0;
    endtask

    // one request transaction; queue the typed or predicted response
    task automatic issue_request(cflp_pkg::req_t r, bit typed, cflp_pkg::rsp_t want);
        cflp_pkg::rsp_t predicted;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_log_position(r);
        expected_positions.push_back(typed ? want : predicted);
    endtask

    task automatic run_phase(cflp_pkg::cfg_data_t pages, cflp_pkg::cfg_data_t en_word,
                             int n);
        write_reg(cflp_pkg::CFG_PAGE_COUNT, pages);
        write_reg(cflp_pkg::CFG_ENABLE, en_word);
        repeat (n)
        begin
            if ($urandom_range(0, 149) == 0)
                drain_responses(SETTLE_CYCLES);
            issue_request(random_request(), 1'b0, '0);
        end
    endtask

    // response stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            rsp_stall <= 1'b0;
    end

    // response checker
    always @(posedge clk)
    begin
        cflp_pkg::rsp_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_positions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("response with nothing pending: %h", rsp_data);
            end
            else
            begin
                want = expected_positions.pop_front();
                if (rsp_data.status !== want.status || rsp_data.page !== want.page ||
                    rsp_data.slot !== want.slot ||
                    rsp_data.erase_request !== want.erase_request ||
                    rsp_data.erase_target !== want.erase_target ||
                    rsp_data.record_count !== want.record_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: st=%0d pg=%0d sl=%0d er=%0b es=%0d cnt=%0d",
                                 want.status, want.page, want.slot, want.erase_request,
                                 want.erase_target, want.record_count);
                        $display("         got: st=%0d pg=%0d sl=%0d er=%0b es=%0d cnt=%0d",
                                 rsp_data.status, rsp_data.page, rsp_data.slot,
                                 rsp_data.erase_request, rsp_data.erase_target,
                                 rsp_data.record_count);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("circular_flash_log_pointer_unit_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // reset values, first append, out of range lookups
        add_chk(cflp_pkg::FUNC_LOOKUP, 32'd0, cflp_pkg::STATUS_RANGE, 32'd0);
        add_chk(cflp_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, cflp_pkg::STATUS_RANGE, 32'd0);
        add_chk(cflp_pkg::FUNC_APPEND, 32'hFFFF_FFFF, cflp_pkg::STATUS_OK, 32'd1);
        add_req(cflp_pkg::FUNC_LOOKUP, 32'd0, 1);
        add_chk(cflp_pkg::FUNC_LOOKUP, 32'd1, cflp_pkg::STATUS_RANGE, 32'd1);
        // disabled: append refused, lookup still served; spare indexes ignored
        add_cfg(cflp_pkg::CFG_ENABLE, 13'h1FFE);
        add_chk(cflp_pkg::FUNC_APPEND, 32'd0, cflp_pkg::STATUS_REFUSED, 32'd1);
        add_cfg(CFG_SPARE_A, 13'h1FFF);
        add_cfg(CFG_SPARE_B, 13'h0000);
        add_req(cflp_pkg::FUNC_LOOKUP, 32'd0, 1);
        add_cfg(cflp_pkg::CFG_ENABLE, 13'h0001);
        // single page area: sector entry with zero sectors, wrapped lookups
        add_cfg(cflp_pkg::CFG_PAGE_COUNT, 13'd1);
        add_req(cflp_pkg::FUNC_APPEND, 32'd0, 15);
        add_req(cflp_pkg::FUNC_LOOKUP, 32'd15, 1);
        add_chk(cflp_pkg::FUNC_LOOKUP, 32'd16, cflp_pkg::STATUS_RANGE, 32'd16);
        add_req(cflp_pkg::FUNC_APPEND, 32'd0, 1);
        add_req(cflp_pkg::FUNC_LOOKUP, 32'd16, 1);
        // page count of zero and above the maximum fall back to the maximum
        add_cfg(cflp_pkg::CFG_PAGE_COUNT, 13'd0);
        add_req(cflp_pkg::FUNC_LOOKUP, 32'd3, 1);
        add_cfg(cflp_pkg::CFG_PAGE_COUNT, 13'h1FFF);
        add_req(cflp_pkg::FUNC_APPEND, 32'd0, 1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                repeat (plan[i].reps)
                    issue_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        // random phases over several area sizes and enable settings
        run_phase(13'd4096, 13'h0001, 200);
        run_phase(13'd1,    13'h0001, 150);
        run_phase(13'd32,   13'h0001, 250);
        run_phase(13'd16,   13'h0001, 150);
        run_phase(13'd40,   13'h1FFF, 150);
        run_phase(13'd48,   13'h0000, 100);
        run_phase(13'd0,    13'h0001, 150);
        run_phase(13'h1FFF, 13'h0001, 100);
        run_phase(13'd32,   13'h0001, 300);
        idle_on = 1'b0;
        run_phase(13'd4096, 13'h0001, 420);

        drain_responses(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("circular_flash_log_pointer_unit_tb: done, clean");
        else
            $display("circular_flash_log_pointer_unit_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cflp_pkg.sv
hw/rtl/cflp_div.sv
hw/rtl/circular_flash_log_pointer_unit.sv
tb/sv/circular_flash_log_pointer_unit_tb.sv
